// File: src/ogru_pkg.sv
// Shared types, constants and register codes for the occupancy grid ray update block.
// No dependencies; ogru_coord_map, ogru_line_walk and the top level import this package.
package ogru_pkg;

    localparam int GRID_DIM_DEF  = 128;
    localparam int CELL_BITS_DEF = 8;

    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int MAG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VALUE_W    = 8;
    localparam int COUNT_W    = 8;

    localparam logic CMD_RAY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_RES   = 3'd0,
        CFG_GRID      = 3'd1,
        CFG_FREE      = 3'd2,
        CFG_OCCUPIED  = 3'd3,
        CFG_FLOOR     = 3'd4,
        CFG_CEILING   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_APPLIED  = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_READ     = 2'd2
    } status_t;

    localparam logic [15:0]        INV_RES_RST  = 16'd1280;
    localparam logic [7:0]         GRID_RST     = 8'd120;
    localparam logic signed [7:0]  FREE_RST     = -8'sd6;
    localparam logic signed [7:0]  OCCUPIED_RST = 8'sd14;
    localparam logic signed [7:0]  FLOOR_RST    = -8'sd64;
    localparam logic signed [7:0]  CEILING_RST  = 8'sd64;

    typedef struct packed {
        logic done;
        logic in_range;
    } map_status_t;

    typedef struct packed {
        logic vld;
        logic last;
    } walk_issue_t;

endpackage

// File: src/ogru_cell_mem.sv
// Log-odds map storage: one write port, one read port, registered read data.
// Plain synchronous memory, no package dependency.
module ogru_cell_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ogru_coord_map.sv
// World to cell conversion: one shared multiplier maps the four ray coordinates in turn.
// Depends on ogru_pkg for widths and the status struct.
module ogru_coord_map #(
    parameter int GRID_DIM = ogru_pkg::GRID_DIM_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [ogru_pkg::COORD_W-1:0]   start_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]   start_y,
    input  logic signed [ogru_pkg::COORD_W-1:0]   end_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]   end_y,
    input  logic [ogru_pkg::COORD_W-1:0]          inv_res,
    input  logic [ogru_pkg::MAG_W-1:0]            grid_n,
    output ogru_pkg::map_status_t                 status,
    output logic [$clog2(GRID_DIM)-1:0]           x0,
    output logic [$clog2(GRID_DIM)-1:0]           y0,
    output logic [$clog2(GRID_DIM)-1:0]           x1,
    output logic [$clog2(GRID_DIM)-1:0]           y1
);
    import ogru_pkg::*;

    localparam int CW = $clog2(GRID_DIM);
    localparam int PW = 2 * COORD_W + 1;

    logic signed [COORD_W-1:0] co_reg [4];
    logic [CW-1:0]             cell_reg [4];
    logic [3:0]                ok_reg;
    logic                      busy_reg;
    logic                      mul_vld_reg;
    logic                      done_reg;
    logic [1:0]                mul_idx_reg;
    logic [1:0]                prod_idx_reg;
    logic signed [PW-1:0]      prod_reg;

    logic                      prod_neg;
    logic [PW-1:0]             prod_abs;
    logic [MAG_W-1:0]          mag;
    logic                      mag_ok;

    // truncate toward zero: a small negative product maps to cell zero
    always_comb begin
        prod_neg = prod_reg[PW-1];
        prod_abs = prod_neg ? PW'(-prod_reg) : PW'(prod_reg);
        mag      = prod_abs[PW-1:FRAC_W];
        mag_ok   = (!prod_neg || (mag == '0)) && (mag < grid_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            mul_idx_reg <= '0;
        end else begin
            done_reg <= mul_vld_reg && (prod_idx_reg == 2'd3);
            if (start) begin
                busy_reg    <= 1'b1;
                mul_idx_reg <= '0;
                mul_vld_reg <= 1'b0;
            end else if (busy_reg) begin
                mul_vld_reg <= 1'b1;
                mul_idx_reg <= mul_idx_reg + 2'd1;
                if (mul_idx_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                mul_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            co_reg[0] <= start_x;
            co_reg[1] <= start_y;
            co_reg[2] <= end_x;
            co_reg[3] <= end_y;
        end
        if (busy_reg) begin
            prod_reg     <= co_reg[mul_idx_reg] * $signed({1'b0, inv_res});
            prod_idx_reg <= mul_idx_reg;
        end
        if (mul_vld_reg) begin
            cell_reg[prod_idx_reg] <= mag[CW-1:0];
            ok_reg[prod_idx_reg]   <= mag_ok;
        end
    end

    assign status.done     = done_reg;
    assign status.in_range = &ok_reg;
    assign x0 = cell_reg[0];
    assign y0 = cell_reg[1];
    assign x1 = cell_reg[2];
    assign y1 = cell_reg[3];

endmodule

// File: src/ogru_line_walk.sv
// Bresenham line stepper: issues one map address per cycle from start cell to end cell.
// Depends on ogru_pkg for the issue struct.
module ogru_line_walk #(
    parameter int GRID_DIM = ogru_pkg::GRID_DIM_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [$clog2(GRID_DIM)-1:0]                  x0,
    input  logic [$clog2(GRID_DIM)-1:0]                  y0,
    input  logic [$clog2(GRID_DIM)-1:0]                  x1,
    input  logic [$clog2(GRID_DIM)-1:0]                  y1,
    output ogru_pkg::walk_issue_t                        issue,
    output logic [$clog2(GRID_DIM*GRID_DIM)-1:0]         addr
);
    import ogru_pkg::*;

    localparam int CW  = $clog2(GRID_DIM);
    localparam int AW  = $clog2(GRID_DIM * GRID_DIM);
    localparam int EW  = CW + 3;
    localparam int EW1 = EW + 1;

    logic                 active_reg;
    logic [CW-1:0]        x_reg;
    logic [CW-1:0]        y_reg;
    logic [CW-1:0]        xe_reg;
    logic [CW-1:0]        ye_reg;
    logic                 xinc_reg;
    logic                 yinc_reg;
    logic signed [EW-1:0] dx_reg;
    logic signed [EW-1:0] dy_reg;
    logic signed [EW-1:0] err_reg;

    logic [CW-1:0]        dx_abs;
    logic [CW-1:0]        dy_abs;
    logic signed [EW-1:0] dx_s;
    logic signed [EW-1:0] dy_s;
    logic                 at_end;
    logic signed [EW1-1:0] e2;
    logic                 step_x;
    logic                 step_y;
    logic signed [EW-1:0] err_next;

    always_comb begin
        dx_abs   = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
        dy_abs   = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
        dx_s     = $signed(EW'(dx_abs));
        dy_s     = -$signed(EW'(dy_abs));
        at_end   = (x_reg == xe_reg) && (y_reg == ye_reg);
        e2       = EW1'(err_reg) <<< 1;
        step_x   = e2 >= EW1'(dy_reg);
        step_y   = e2 <= EW1'(dx_reg);
        err_next = err_reg + (step_x ? dy_reg : EW'(0)) + (step_y ? dx_reg : EW'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (start) begin
            active_reg <= 1'b1;
        end else if (active_reg && at_end) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x0;
            y_reg    <= y0;
            xe_reg   <= x1;
            ye_reg   <= y1;
            xinc_reg <= x0 < x1;
            yinc_reg <= y0 < y1;
            dx_reg   <= dx_s;
            dy_reg   <= dy_s;
            err_reg  <= dx_s + dy_s;
        end else if (active_reg && !at_end) begin
            err_reg <= err_next;
            if (step_x) begin
                x_reg <= xinc_reg ? x_reg + CW'(1) : x_reg - CW'(1);
            end
            if (step_y) begin
                y_reg <= yinc_reg ? y_reg + CW'(1) : y_reg - CW'(1);
            end
        end
    end

    assign issue.vld  = active_reg;
    assign issue.last = at_end;
    assign addr       = AW'(y_reg) * AW'(GRID_DIM) + AW'(x_reg);

endmodule

// File: src/occupancy_grid_ray_update.sv
// Occupancy grid ray update. After reset the map is swept to zero, one cell a cycle, over all
// GRID_DIM*GRID_DIM cells (16384 by default), and s_ready stays low until the sweep ends;
// configuration writes are taken throughout. A ray request maps its four coordinates through
// one shared multiplier, then walks the line one cell per cycle, max(|dx|,|dy|)+1 cells,
// since every cell is one read-modify-write on the single map memory (the end cell is written
// only for a hit) with the read of the next cell overlapping the write of the previous one.
// A rejected ray skips the walk.
// Depends on ogru_pkg, ogru_cell_mem, ogru_coord_map and ogru_line_walk.
module occupancy_grid_ray_update #(
    parameter int GRID_DIM  = ogru_pkg::GRID_DIM_DEF,
    parameter int CELL_BITS = ogru_pkg::CELL_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ogru_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic signed [ogru_pkg::COORD_W-1:0]   s_start_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]   s_start_y,
    input  logic signed [ogru_pkg::COORD_W-1:0]   s_end_x,
    input  logic signed [ogru_pkg::COORD_W-1:0]   s_end_y,
    input  logic                                  s_hit,
    input  logic [6:0]                            s_cell_col,
    input  logic [6:0]                            s_cell_row,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [ogru_pkg::COUNT_W-1:0]          m_cells_touched,
    output logic signed [ogru_pkg::VALUE_W-1:0]   m_cell_value
);
    import ogru_pkg::*;

    localparam int CW    = $clog2(GRID_DIM);
    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((CELL_BITS > 8) ? CELL_BITS : 8) + 1;
    localparam logic signed [SW-1:0] CellMax = SW'((1 <<< (CELL_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] CellMin = SW'(-(1 <<< (CELL_BITS - 1)));

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MAP   = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_RDATA = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]       inv_res_reg;
    logic [7:0]        grid_reg;
    logic signed [7:0] free_reg;
    logic signed [7:0] occ_reg;
    logic signed [7:0] floor_reg;
    logic signed [7:0] ceil_reg;

    logic [AW-1:0]     clr_cnt_reg;
    logic              hit_reg;
    logic              rd_ok_reg;
    logic [AW-1:0]     rd_addr_reg;

    logic              pend_vld_reg;
    logic              pend_last_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [COUNT_W-1:0] touched_reg;

    status_t            res_status_reg;
    logic [COUNT_W-1:0] res_touched_reg;
    logic [VALUE_W-1:0] res_value_reg;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [COUNT_W-1:0] m_touched_reg;
    logic [VALUE_W-1:0] m_value_reg;

    logic               accept_in;
    logic               out_free;
    logic               map_start;
    logic               walk_start;
    logic [MAG_W-1:0]   grid_n;
    map_status_t        map_st;
    logic [CW-1:0]      cx0, cy0, cx1, cy1;
    walk_issue_t        issue;
    logic [AW-1:0]      walk_addr;

    logic [CELL_BITS-1:0] mem_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CELL_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;

    logic                 upd_we;
    logic signed [SW-1:0] q_ext;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat_c;
    logic signed [SW-1:0] sat_f;
    logic signed [SW-1:0] new_val;
    logic [COUNT_W-1:0]   touched_inc;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept_in  = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign map_start  = accept_in && (s_cmd == CMD_RAY);
    assign walk_start = (state_reg == ST_MAP) && map_st.done && map_st.in_range;
    assign grid_n     = (MAG_W'(grid_reg) > MAG_W'(GRID_DIM)) ? MAG_W'(GRID_DIM)
                                                               : MAG_W'(grid_reg);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_res_reg <= INV_RES_RST;
            grid_reg    <= GRID_RST;
            free_reg    <= FREE_RST;
            occ_reg     <= OCCUPIED_RST;
            floor_reg   <= FLOOR_RST;
            ceil_reg    <= CEILING_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INV_RES:  inv_res_reg <= cfg_wdata;
                CFG_GRID:     grid_reg    <= cfg_wdata[7:0];
                CFG_FREE:     free_reg    <= cfg_wdata[7:0];
                CFG_OCCUPIED: occ_reg     <= cfg_wdata[7:0];
                CFG_FLOOR:    floor_reg   <= cfg_wdata[7:0];
                CFG_CEILING:  ceil_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    ogru_coord_map #(
        .GRID_DIM (GRID_DIM)
    ) u_coord_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (map_start),
        .start_x  (s_start_x),
        .start_y  (s_start_y),
        .end_x    (s_end_x),
        .end_y    (s_end_y),
        .inv_res  (inv_res_reg),
        .grid_n   (grid_n),
        .status   (map_st),
        .x0       (cx0),
        .y0       (cy0),
        .x1       (cx1),
        .y1       (cy1)
    );

    ogru_line_walk #(
        .GRID_DIM (GRID_DIM)
    ) u_line_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (walk_start),
        .x0       (cx0),
        .y0       (cy0),
        .x1       (cx1),
        .y1       (cy1),
        .issue    (issue),
        .addr     (walk_addr)
    );

    ogru_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CELL_BITS)
    ) u_cell_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // cell update: saturate to cell range, then floor, then ceiling
    always_comb begin
        q_ext   = SW'($signed(mem_rdata));
        delta   = pend_last_reg ? SW'(occ_reg) : SW'(free_reg);
        sum     = q_ext + delta;
        sat_c   = (sum > CellMax) ? CellMax : ((sum < CellMin) ? CellMin : sum);
        sat_f   = (sat_c < SW'(floor_reg)) ? SW'(floor_reg) : sat_c;
        new_val = (sat_f > SW'(ceil_reg)) ? SW'(ceil_reg) : sat_f;
        upd_we  = pend_vld_reg && (!pend_last_reg || hit_reg);
        touched_inc = (touched_reg == '1) ? touched_reg : touched_reg + COUNT_W'(1);
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = upd_we;
            mem_waddr = pend_addr_reg;
            mem_wdata = new_val[CELL_BITS-1:0];
        end
        mem_raddr = (state_reg == ST_READ) ? rd_addr_reg : walk_addr;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept_in) state_next = (s_cmd == CMD_READ) ? ST_READ : ST_MAP;
            ST_MAP:   if (map_st.done) state_next = map_st.in_range ? ST_WALK : ST_RESP;
            ST_WALK:  if (pend_vld_reg && pend_last_reg) state_next = ST_RESP;
            ST_READ:  state_next = ST_RDATA;
            ST_RDATA: state_next = ST_RESP;
            ST_RESP:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= issue.vld;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if ((state_reg == ST_RESP) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_last_reg <= issue.last;
        pend_addr_reg <= walk_addr;
        if (accept_in) begin
            hit_reg     <= s_hit;
            rd_ok_reg   <= (32'(s_cell_col) < GRID_DIM) && (32'(s_cell_row) < GRID_DIM);
            rd_addr_reg <= AW'(s_cell_row) * AW'(GRID_DIM) + AW'(s_cell_col);
        end
        if (walk_start) begin
            touched_reg <= '0;
        end else if (upd_we) begin
            touched_reg <= touched_inc;
        end
        if ((state_reg == ST_MAP) && map_st.done && !map_st.in_range) begin
            res_status_reg  <= STATUS_REJECTED;
            res_touched_reg <= '0;
            res_value_reg   <= '0;
        end
        if ((state_reg == ST_WALK) && pend_vld_reg && pend_last_reg) begin
            res_status_reg  <= STATUS_APPLIED;
            res_touched_reg <= upd_we ? touched_inc : touched_reg;
            res_value_reg   <= upd_we ? new_val[VALUE_W-1:0] : q_ext[VALUE_W-1:0];
        end
        if (state_reg == ST_RDATA) begin
            res_status_reg  <= STATUS_READ;
            res_touched_reg <= '0;
            res_value_reg   <= rd_ok_reg ? q_ext[VALUE_W-1:0] : '0;
        end
        if ((state_reg == ST_RESP) && out_free) begin
            m_status_reg  <= res_status_reg;
            m_touched_reg <= res_touched_reg;
            m_value_reg   <= res_value_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_cells_touched = m_touched_reg;
    assign m_cell_value    = $signed(m_value_reg);

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during map clear");

    a_issue_only_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        issue.vld |-> (state_reg == ST_WALK))
        else $error("map address issued outside a ray walk");

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) || (state_reg == ST_RESP)) |-> !mem_we)
        else $error("map written with no ray in progress");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && pend_vld_reg && pend_last_reg) |=> (state_reg == ST_RESP))
        else $error("ray walk did not end after its last cell");

endmodule
